// ===== sv/swfp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swfp_pkg
// Types and constants shared by the sync-word frame parser modules.
// ----------------------------------------------------------------------------
package swfp_pkg;

	localparam int unsigned COUNT_W   = 3;
	localparam int unsigned IN_DATA_W = 8;
	localparam int unsigned RES_W     = 49;
	localparam int unsigned OUT_DATA_W = ((RES_W + 7) / 8) * 8;

	localparam logic [COUNT_W-1:0] SYNC_LEN   = 3'd4;
	localparam logic [7:0]         POS_LENGTH = 8'd4;
	localparam logic [7:0]         POS_NUMBER = 8'd5;
	localparam logic [7:0]         POS_NUMBER_HI = 8'd6;
	localparam logic [7:0]         POS_TYPE   = 8'd7;
	localparam logic [7:0]         POS_WORD   = 8'd8;
	localparam logic [7:0]         POS_WORD_HI = 8'd9;
	localparam logic [7:0]         MIN_FRAME  = 8'd8;
	localparam logic [31:0]        SYNC_RESET = 32'hA419_E865;

	// Packed so that the first field lands in the highest bits.
	typedef struct packed {
		logic        short_frame;
		logic [15:0] payload_word;
		logic [7:0]  frame_length;
		logic [15:0] frame_number;
		logic [7:0]  frame_type;
	} result_t;

	typedef struct packed {
		logic               in_frame;
		logic [COUNT_W-1:0] matched;
		logic [7:0]         offset;
	} parse_status_t;

endpackage
`default_nettype wire

// ===== sv/swfp_parse.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swfp_parse
// Sync hunt, header capture and end-of-frame detection for one byte a cycle while step is high.
// ----------------------------------------------------------------------------
module swfp_parse
	import swfp_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [31:0]   cfg_wdata,
	input  wire logic [7:0]    byte_s1,
	input  wire logic          step,
	output logic               emit,
	output result_t            res,
	output parse_status_t      status
);

	logic [31:0]        sync_word_q;
	logic [COUNT_W-1:0] matched_q, matched_d;
	logic [7:0]         offset_q, offset_d;
	logic [7:0]         length_q, length_d;
	logic [15:0]        number_q, number_d;
	logic [7:0]         type_q, type_d;
	logic [15:0]        word_q, word_d;
	logic               in_frame;
	logic [7:0]         expect_byte;
	logic [7:0]         total;
	logic [8:0]         off_next;

	assign in_frame    = matched_q[2];
	assign expect_byte = sync_word_q[{matched_q[1:0], 3'b000} +: 8];
	assign total       = (length_d < MIN_FRAME) ? MIN_FRAME : length_d;
	assign off_next    = {1'b0, offset_q} + 9'd1;

	always_comb begin
		matched_d = matched_q;
		offset_d  = offset_q;
		length_d  = length_q;
		number_d  = number_q;
		type_d    = type_q;
		word_d    = word_q;
		emit      = 1'b0;
		if (!in_frame) begin
			if (byte_s1 == expect_byte) begin
				matched_d = matched_q + 3'd1;
				if (matched_d == SYNC_LEN) begin
					offset_d = POS_LENGTH;
					length_d = '0;
					number_d = '0;
					type_d   = '0;
					word_d   = '0;
				end
			end else begin
				matched_d = '0;
			end
		end else begin
			if (offset_q == POS_LENGTH) begin
				length_d = byte_s1;
			end else if (offset_q < length_q) begin
				// Bytes past the declared length leave their field at zero.
				if (offset_q == POS_NUMBER)             number_d[7:0]  = byte_s1;
				else if (offset_q == POS_NUMBER_HI)     number_d[15:8] = byte_s1;
				else if (offset_q == POS_TYPE)          type_d         = byte_s1;
				else if (offset_q == POS_WORD)          word_d[7:0]    = byte_s1;
				else if (offset_q == POS_WORD_HI)       word_d[15:8]   = byte_s1;
			end
			if (off_next >= {1'b0, total}) begin
				emit      = 1'b1;
				matched_d = '0;
				offset_d  = '0;
			end else begin
				offset_d = off_next[7:0];
			end
		end
	end

	assign res.frame_type   = type_d;
	assign res.frame_number = number_d;
	assign res.frame_length = length_d;
	assign res.payload_word = word_d;
	assign res.short_frame  = (length_d < MIN_FRAME);

	assign status.in_frame = in_frame;
	assign status.matched  = matched_q;
	assign status.offset   = offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_word_q <= SYNC_RESET;
		end else if (cfg_we) begin
			sync_word_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matched_q <= '0;
			offset_q  <= '0;
			length_q  <= '0;
			number_q  <= '0;
			type_q    <= '0;
			word_q    <= '0;
		end else if (step) begin
			matched_q <= matched_d;
			offset_q  <= offset_d;
			length_q  <= length_d;
			number_q  <= number_d;
			type_q    <= type_d;
			word_q    <= word_d;
		end
	end

endmodule
`default_nettype wire

// ===== sv/swfp_result_reg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swfp_result_reg
// Output register holding one finished frame result until it is taken.
// ----------------------------------------------------------------------------
module swfp_result_reg
	import swfp_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    load,
	input  wire result_t res_in,
	output logic         can_load,
	input  wire logic    m_tready,
	output logic         m_tvalid,
	output result_t      res_out
);

	logic    valid_q;
	result_t res_q;

	assign can_load = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign res_out  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule
`default_nettype wire

// ===== sv/sync_word_frame_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sync_word_frame_parser
// Byte-stream parser for sync-word, length-prefixed frames.
// ----------------------------------------------------------------------------
// Takes one byte per cycle on the slave stream, hunts for the four-byte sync
// word held in the configuration register (first byte in bits 7:0) and, once
// in a frame, captures the length, message number, type and payload word.
// One result leaves on the master stream after the frame's last byte, that is
// after max(length, 8) bytes counted from the first sync byte. Each byte sits
// in the input register while the parse logic works on it; the last byte's
// result is then registered in the output register, from which it is valid
// on the master stream. Input stalls only when a frame-ending byte finds the
// output register still full.
// Write the sync word only while the stream is idle.
module sync_word_frame_parser
	import swfp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [31:0]           cfg_wdata,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] data_byte
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// [7:0] frame_type, [23:8] frame_number, [31:24] frame_length,
	// [47:32] payload_word, [48] short_frame, [55:49] zero
	output logic [OUT_DATA_W-1:0]      m_tdata
);

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          emit;
	logic          can_load;
	logic          advance;
	result_t       res_d;
	result_t       res_q;
	parse_status_t status;

	// Hold a frame-ending byte while the previous result waits.
	assign advance  = valid_s1 && (!emit || can_load);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata[7:0];
		end
	end

	swfp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.byte_s1   (byte_s1),
		.step      (advance),
		.emit      (emit),
		.res       (res_d),
		.status    (status)
	);

	swfp_result_reg u_result (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && emit),
		.res_in   (res_d),
		.can_load (can_load),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.res_out  (res_q)
	);

	assign m_tdata = {{(OUT_DATA_W - RES_W){1'b0}}, res_q};

	// A new result never overwrites one still waiting downstream.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit) |-> (!m_tvalid || m_tready))
		else $error("result overwritten while stalled");

	// After a result the parser is back to hunting from the first sync byte.
	a_hunt_after_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit) |=> (status.matched == '0 && status.offset == '0))
		else $error("parser not back to hunt after frame end");

	// Inside a frame the offset never points into the sync bytes.
	a_offset_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		status.in_frame |-> (status.offset >= POS_LENGTH))
		else $error("frame offset below length position");

	// Results come only out of a frame.
	a_emit_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && emit) |-> status.in_frame)
		else $error("result raised while hunting");

endmodule
`default_nettype wire
